### hdl/qrr_pkg.sv
// Shared tag type and root width constant for the quadratic real roots engine.
`default_nettype none
package qrr_pkg;

   localparam int ROOT_WIDTH = 33;

   typedef struct packed {
      logic valid;
      logic has_roots;
      logic degenerate;
   } qrr_tag_type;

endpackage
`default_nettype wire

### hdl/qrr_sqrt_cell.sv
// One digit cell of the pipelined fixed point square root chain.
`default_nettype none
module qrr_sqrt_cell #(
   parameter int DW  = 34,
   parameter int RW  = 33,
   parameter int CW  = 51,
   parameter int POS = 0,
   parameter int FB  = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire qrr_pkg::qrr_tag_type tag_i,
   input  wire logic [DW-1:0]       d_i,
   input  wire logic [RW-1:0]       root_i,
   input  wire logic [RW+1:0]       rem_i,
   input  wire logic [CW-1:0]       carry_i,
   output qrr_pkg::qrr_tag_type     tag_ff,
   output logic [DW-1:0]            d_ff,
   output logic [RW-1:0]            root_ff,
   output logic [RW+1:0]            rem_ff,
   output logic [CW-1:0]            carry_ff
);
   import qrr_pkg::*;

   logic [1:0]    pair;
   logic [RW+3:0] rem_sh;
   logic [RW+3:0] trial;
   logic [RW+3:0] diff;
   logic          ge;
   logic [RW+1:0] rem_in;
   logic [RW-1:0] root_in;

   generate
      if (POS >= FB) begin : g_pair
         assign pair = d_i[2*(POS-FB)+1 -: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end
   endgenerate

   always_comb begin
      rem_sh  = {rem_i, pair};
      trial   = {2'b00, root_i, 2'b01};
      diff    = rem_sh - trial;
      ge      = (rem_sh >= trial);
      rem_in  = ge ? diff[RW+1:0] : rem_sh[RW+1:0];
      root_in = {root_i[RW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (en) begin
         tag_ff <= tag_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff     <= d_i;
         root_ff  <= root_in;
         rem_ff   <= rem_in;
         carry_ff <= carry_i;
      end
   end

endmodule
`default_nettype wire

### hdl/qrr_div_cell.sv
// One quotient bit cell of the two-lane restoring divider chain.
`default_nettype none
module qrr_div_cell #(
   parameter int NW   = 34,
   parameter int DENW = 17,
   parameter int CW   = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire qrr_pkg::qrr_tag_type tag_i,
   input  wire logic [DENW-1:0]     den_i,
   input  wire logic [NW-1:0]       nump_i,
   input  wire logic [NW-1:0]       numm_i,
   input  wire logic [NW-1:0]       qp_i,
   input  wire logic [NW-1:0]       qm_i,
   input  wire logic [DENW-1:0]     remp_i,
   input  wire logic [DENW-1:0]     remm_i,
   input  wire logic [CW-1:0]       carry_i,
   output qrr_pkg::qrr_tag_type     tag_ff,
   output logic [DENW-1:0]          den_ff,
   output logic [NW-1:0]            nump_ff,
   output logic [NW-1:0]            numm_ff,
   output logic [NW-1:0]            qp_ff,
   output logic [NW-1:0]            qm_ff,
   output logic [DENW-1:0]          remp_ff,
   output logic [DENW-1:0]          remm_ff,
   output logic [CW-1:0]            carry_ff
);
   import qrr_pkg::*;

   logic [DENW:0]   shp, shm, dp, dm;
   logic            gep, gem;
   logic [DENW-1:0] remp_in, remm_in;

   always_comb begin
      shp     = {remp_i, nump_i[NW-1]};
      shm     = {remm_i, numm_i[NW-1]};
      dp      = shp - {1'b0, den_i};
      dm      = shm - {1'b0, den_i};
      gep     = (shp >= {1'b0, den_i});
      gem     = (shm >= {1'b0, den_i});
      remp_in = gep ? dp[DENW-1:0] : shp[DENW-1:0];
      remm_in = gem ? dm[DENW-1:0] : shm[DENW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (en) begin
         tag_ff <= tag_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff   <= den_i;
         nump_ff  <= {nump_i[NW-2:0], 1'b0};
         numm_ff  <= {numm_i[NW-2:0], 1'b0};
         qp_ff    <= {qp_i[NW-2:0], gep};
         qm_ff    <= {qm_i[NW-2:0], gem};
         remp_ff  <= remp_in;
         remm_ff  <= remm_in;
         carry_ff <= carry_i;
      end
   end

endmodule
`default_nettype wire

### hdl/quadratic_real_roots.sv
// Top level of the quadratic real roots engine: products, root and divider chains.
// Usage:
//   req_valid/req_stall carry one coefficient set (a, b, c) per transfer.
//   rsp_valid/rsp_stall carry has_roots, degenerate and both roots, one
//   response per request, in order.
//   Throughput is one transfer per cycle while rsp_stall does not hold the
//   chain. The chain is two product stages, one square root cell per root
//   bit, a numerator stage, one divider cell per quotient bit and the
//   output register.
//   The whole chain advances together; while a response waits under
//   rsp_stall the chain holds and req_stall is raised.
//   Reset empties the chain; no responses are pending after it.
//   A zero quadratic coefficient gives degenerate = 1 and zero roots; a
//   negative discriminant gives has_roots = 0 and zero roots.
`default_nettype none
module quadratic_real_roots #(
   parameter int COEF_WIDTH = 16,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [COEF_WIDTH-1:0]         req_coef_a,
   input  wire logic signed [COEF_WIDTH-1:0]         req_coef_b,
   input  wire logic signed [COEF_WIDTH-1:0]         req_coef_c,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_has_roots,
   output logic                                      rsp_degenerate,
   output logic signed [qrr_pkg::ROOT_WIDTH-1:0]     rsp_root_plus,
   output logic signed [qrr_pkg::ROOT_WIDTH-1:0]     rsp_root_minus
);
   import qrr_pkg::*;

   localparam int W    = COEF_WIDTH;
   localparam int FB   = FRAC_BITS;
   localparam int PW   = 2 * W;
   localparam int XW   = 2 * W + 2;
   localparam int DW   = (XW > 64) ? 64 : XW;
   localparam int H    = DW / 2;
   localparam int RW   = H + FB;
   localparam int NBW  = W + FB + 1;
   localparam int DENW = W + 1;
   localparam int SCW  = 1 + NBW + DENW;
   localparam int NW   = ((NBW > RW) ? NBW : RW) + 1;
   localparam int EW   = ((NW > ROOT_WIDTH + 1) ? NW : ROOT_WIDTH + 1) + 1;
   localparam int NSQ  = RW;

   localparam logic signed [EW-1:0] HI = (EW'(1) <<< (ROOT_WIDTH - 1)) - EW'(1);
   localparam logic signed [EW-1:0] LO = -HI - EW'(1);

   logic en;
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // product stage
   qrr_tag_type             p_tag_ff;
   logic signed [PW-1:0]    bb_ff, ac_ff;
   logic signed [W-1:0]     pa_ff, pb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_tag_ff <= '0;
      end else if (en) begin
         p_tag_ff <= '{valid: req_valid, has_roots: 1'b0, degenerate: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bb_ff <= PW'(req_coef_b) * PW'(req_coef_b);
         ac_ff <= PW'(req_coef_a) * PW'(req_coef_c);
         pa_ff <= req_coef_a;
         pb_ff <= req_coef_b;
      end
   end

   // discriminant stage
   logic signed [XW-1:0]  disc_x;
   logic [DW-1:0]         disc;
   logic signed [NBW-1:0] nb_x;
   logic [DENW-1:0]       den_x;
   logic signed [DENW-1:0] a2_x;
   qrr_tag_type           d_tag_in;

   always_comb begin
      disc_x = XW'(bb_ff) - (XW'(ac_ff) <<< 2);
      disc   = disc_x[DW-1:0];
      nb_x   = -(NBW'(pb_ff) <<< FB);
      a2_x   = DENW'(pa_ff) <<< 1;
      den_x  = a2_x[DENW-1] ? DENW'(-a2_x) : DENW'(a2_x);
      d_tag_in.valid      = p_tag_ff.valid;
      d_tag_in.has_roots  = !disc[DW-1];
      d_tag_in.degenerate = (pa_ff == '0);
   end

   qrr_tag_type     sq_tag  [0:NSQ];
   logic [DW-1:0]   sq_d    [0:NSQ];
   logic [RW-1:0]   sq_root [0:NSQ];
   logic [RW+1:0]   sq_rem  [0:NSQ];
   logic [SCW-1:0]  sq_car  [0:NSQ];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_tag[0] <= '0;
      end else if (en) begin
         sq_tag[0] <= d_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_d[0]    <= disc;
         sq_root[0] <= '0;
         sq_rem[0]  <= '0;
         sq_car[0]  <= {pa_ff[W-1], nb_x, den_x};
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < NSQ; gi++) begin : g_sq
         qrr_sqrt_cell #(
            .DW(DW), .RW(RW), .CW(SCW), .POS(RW - 1 - gi), .FB(FB)
         ) u_cell (
            .clock(clock), .reset(reset), .en(en),
            .tag_i(sq_tag[gi]), .d_i(sq_d[gi]), .root_i(sq_root[gi]),
            .rem_i(sq_rem[gi]), .carry_i(sq_car[gi]),
            .tag_ff(sq_tag[gi+1]), .d_ff(sq_d[gi+1]), .root_ff(sq_root[gi+1]),
            .rem_ff(sq_rem[gi+1]), .carry_ff(sq_car[gi+1])
         );
      end
   endgenerate

   // numerator stage
   logic                  s_aneg;
   logic signed [NBW-1:0] s_nb;
   logic [DENW-1:0]       s_den;
   logic signed [NW-1:0]  nump_x, numm_x;
   logic [NW-1:0]         unp, unm;

   always_comb begin
      s_aneg = sq_car[NSQ][SCW-1];
      s_nb   = sq_car[NSQ][SCW-2 -: NBW];
      s_den  = sq_car[NSQ][DENW-1:0];
      nump_x = NW'(s_nb) + $signed(NW'(sq_root[NSQ]));
      numm_x = NW'(s_nb) - $signed(NW'(sq_root[NSQ]));
      unp    = nump_x[NW-1] ? NW'(-nump_x) : NW'(nump_x);
      unm    = numm_x[NW-1] ? NW'(-numm_x) : NW'(numm_x);
   end

   qrr_tag_type     dv_tag  [0:NW];
   logic [DENW-1:0] dv_den  [0:NW];
   logic [NW-1:0]   dv_nump [0:NW];
   logic [NW-1:0]   dv_numm [0:NW];
   logic [NW-1:0]   dv_qp   [0:NW];
   logic [NW-1:0]   dv_qm   [0:NW];
   logic [DENW-1:0] dv_remp [0:NW];
   logic [DENW-1:0] dv_remm [0:NW];
   logic [1:0]      dv_car  [0:NW];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_tag[0] <= '0;
      end else if (en) begin
         dv_tag[0] <= sq_tag[NSQ];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_den[0]  <= s_den;
         dv_nump[0] <= unp;
         dv_numm[0] <= unm;
         dv_qp[0]   <= '0;
         dv_qm[0]   <= '0;
         dv_remp[0] <= '0;
         dv_remm[0] <= '0;
         dv_car[0]  <= {nump_x[NW-1] ^ s_aneg, numm_x[NW-1] ^ s_aneg};
      end
   end

   generate
      for (gi = 0; gi < NW; gi++) begin : g_dv
         qrr_div_cell #(.NW(NW), .DENW(DENW), .CW(2)) u_cell (
            .clock(clock), .reset(reset), .en(en),
            .tag_i(dv_tag[gi]), .den_i(dv_den[gi]),
            .nump_i(dv_nump[gi]), .numm_i(dv_numm[gi]),
            .qp_i(dv_qp[gi]), .qm_i(dv_qm[gi]),
            .remp_i(dv_remp[gi]), .remm_i(dv_remm[gi]), .carry_i(dv_car[gi]),
            .tag_ff(dv_tag[gi+1]), .den_ff(dv_den[gi+1]),
            .nump_ff(dv_nump[gi+1]), .numm_ff(dv_numm[gi+1]),
            .qp_ff(dv_qp[gi+1]), .qm_ff(dv_qm[gi+1]),
            .remp_ff(dv_remp[gi+1]), .remm_ff(dv_remm[gi+1]),
            .carry_ff(dv_car[gi+1])
         );
      end
   endgenerate

   // output stage
   logic signed [EW-1:0] qpe, qme, rp_x, rm_x;
   logic                 zero_out;
   logic [ROOT_WIDTH-1:0] rp_in, rm_in;

   always_comb begin
      qpe = $signed(EW'(dv_qp[NW]));
      qme = $signed(EW'(dv_qm[NW]));
      if (dv_car[NW][1]) begin
         rp_x = (qpe > -LO) ? LO : -qpe;
      end else begin
         rp_x = (qpe > HI) ? HI : qpe;
      end
      if (dv_car[NW][0]) begin
         rm_x = (qme > -LO) ? LO : -qme;
      end else begin
         rm_x = (qme > HI) ? HI : qme;
      end
      zero_out = !dv_tag[NW].has_roots || dv_tag[NW].degenerate;
      rp_in    = zero_out ? '0 : rp_x[ROOT_WIDTH-1:0];
      rm_in    = zero_out ? '0 : rm_x[ROOT_WIDTH-1:0];
   end

   logic valid_ff;
   assign rsp_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= dv_tag[NW].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_has_roots  <= dv_tag[NW].has_roots;
         rsp_degenerate <= dv_tag[NW].degenerate;
         rsp_root_plus  <= rp_in;
         rsp_root_minus <= rm_in;
      end
   end

`ifndef SYNTHESIS
   a_degen_has_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_has_roots)
      else $error("degenerate response without roots flag");

   a_zero_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!rsp_has_roots || rsp_degenerate) |->
         (rsp_root_plus == '0) && (rsp_root_minus == '0))
      else $error("roots not cleared");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_root_plus))
      else $error("response dropped under stall");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall mismatch");
`endif

endmodule
`default_nettype wire

### tb/quadratic_real_roots_checker.sv
// Checker for the quadratic real roots engine: predicts each response and compares it.
`timescale 1ns / 1ps
module quadratic_real_roots_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire logic                               req_stall,
   input  wire logic signed [15:0]                 req_coef_a,
   input  wire logic signed [15:0]                 req_coef_b,
   input  wire logic signed [15:0]                 req_coef_c,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   input  wire logic                               rsp_has_roots,
   input  wire logic                               rsp_degenerate,
   input  wire logic signed [qrr_pkg::ROOT_WIDTH-1:0] rsp_root_plus,
   input  wire logic signed [qrr_pkg::ROOT_WIDTH-1:0] rsp_root_minus,
   output int                                      error_count,
   output int                                      pending_count
);
   localparam int FRAC = 16;
   localparam int RW = qrr_pkg::ROOT_WIDTH;

   typedef struct packed {
      logic          has_roots;
      logic          degenerate;
      logic [RW-1:0] root_plus;
      logic [RW-1:0] root_minus;
   } roots_type;

   roots_type pending_roots[$];

   function automatic logic [63:0] floor_sqrt_fixed(logic [63:0] d);
      logic [127:0] rem, root, trial;
      logic [63:0]  pair;
      rem = 0;
      root = 0;
      for (int i = 31 + FRAC; i >= 0; i--) begin
         pair = 0;
         if (i >= FRAC) pair = (d >> (2 * (i - FRAC))) & 64'd3;
         rem = (rem << 2) | pair;
         trial = (root << 2) | 1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      end
      return root[63:0];
   endfunction

   function automatic logic [RW-1:0] quotient_sat(longint num, longint den);
      longint hi, lo, q, un, ud;
      hi = (longint'(1) <<< (RW - 1)) - 1;
      lo = -hi - 1;
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      q = un / ud;
      if ((num < 0) != (den < 0)) return (q > hi + 1) ? lo[RW-1:0] : RW'(-q);
      return (q > hi) ? hi[RW-1:0] : q[RW-1:0];
   endfunction

   function automatic roots_type solve_quadratic(logic signed [15:0] a,
                                                 logic signed [15:0] b,
                                                 logic signed [15:0] c);
      roots_type r;
      longint la, lb, lc, d, s, nb;
      la = a;
      lb = b;
      lc = c;
      d = lb * lb - 4 * la * lc;
      r.has_roots = (d >= 0);
      r.degenerate = (a == 0);
      r.root_plus = 0;
      r.root_minus = 0;
      if (r.has_roots && !r.degenerate) begin
         s = longint'(floor_sqrt_fixed(d));
         nb = -lb * (longint'(1) <<< FRAC);
         r.root_plus = quotient_sat(nb + s, 2 * la);
         r.root_minus = quotient_sat(nb - s, 2 * la);
      end
      return r;
   endfunction

   assign pending_count = pending_roots.size();

   always @(posedge clock) begin
      roots_type want;
      if (reset) begin
         error_count <= 0;
         pending_roots.delete();
      end else begin
         if (req_valid && !req_stall)
            pending_roots.push_back(solve_quadratic(req_coef_a, req_coef_b, req_coef_c));
         if (rsp_valid && !rsp_stall) begin
            if (pending_roots.size() == 0) begin
               $display("%0t: unexpected response", $time);
               error_count <= error_count + 1;
            end else begin
               want = pending_roots.pop_front();
               if (want.has_roots !== rsp_has_roots || want.degenerate !== rsp_degenerate ||
                   want.root_plus !== rsp_root_plus || want.root_minus !== rsp_root_minus) begin
                  $display("%0t: expected h=%b d=%b p=%h m=%h actual h=%b d=%b p=%h m=%h",
                           $time, want.has_roots, want.degenerate, want.root_plus,
                           want.root_minus, rsp_has_roots, rsp_degenerate, rsp_root_plus,
                           rsp_root_minus);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

### tb/quadratic_real_roots_tb.sv
// Testbench top for the quadratic real roots engine: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module quadratic_real_roots_tb;
   localparam int RW = qrr_pkg::ROOT_WIDTH;
   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0;
   logic signed [15:0] req_coef_a = 0, req_coef_b = 0, req_coef_c = 0;
   logic req_stall, rsp_valid, rsp_has_roots, rsp_degenerate;
   logic signed [RW-1:0] rsp_root_plus, rsp_root_minus;
   int error_count, pending_count;
   int send_idle_pct = 38, recv_idle_pct = 72;
   int quiet_cycles = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   quadratic_real_roots uut (.*);

   quadratic_real_roots_checker checker_i (.*);

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_coef();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(int'($urandom_range(16)) - 8);
         3: return 16'(int'($urandom_range(512)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      send_coefs(1, 16'hfffd, 2);
      send_coefs(1, 2, 1);
      send_coefs(1, 0, 1);
      send_coefs(0, 5, 7);
      send_coefs(0, 0, 0);
      send_coefs(16'h8000, 16'h8000, 16'h7fff);
      send_coefs(16'h7fff, 16'h8000, 16'h8000);
      send_coefs(16'h8000, 16'h7fff, 16'h8000);
      send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
      send_coefs(1, 16'h8000, 16'h8000);
      send_coefs(16'hffff, 16'h8000, 16'h7fff);
      send_coefs(16'hffff, 16'hffff, 16'hffff);
      send_coefs(2, 16'hffff, 0);
      send_coefs(16'h5555, 16'haaaa, 16'h5555);
      send_coefs(16'haaaa, 16'h5555, 16'haaaa);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 72 : 0;
         recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 38 : 0;
         repeat (262) send_coefs(pick_coef(), pick_coef(), pick_coef());
      end
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
